[rtl/core/tpa_pkg.sv]
// Shared types, constants and helpers for the two-pool block allocator.
package tpa_pkg;

   localparam int SMALL_BLOCKS      = 16;
   localparam int LARGE_BLOCKS      = 4;
   localparam int SMALL_BLOCK_BYTES = 1024;
   localparam int LARGE_BASE        = 268435456;

   localparam int ADDR_W   = 29;
   localparam int SIZE_W   = 24;
   localparam int STATUS_W = 3;
   // boundary addresses of the large pool reach LARGE_BASE + LARGE_BLOCKS * size
   localparam int LANE_W   = ADDR_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [STATUS_W-1:0] {
      ST_SMALL    = 3'd0,
      ST_LARGE    = 3'd1,
      ST_NULL     = 3'd2,
      ST_OVERSIZE = 3'd3,
      ST_FALLBACK = 3'd4,
      ST_FREED    = 3'd5,
      ST_PASSED   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      OP_NULL,
      OP_UNPREP,
      OP_OVERSIZE,
      OP_ALLOC_SMALL,
      OP_ALLOC_LARGE,
      OP_FREE,
      OP_PASS
   } op_type;

   typedef logic [LARGE_BLOCKS:0][LANE_W-1:0] lane_table_type;

   typedef struct packed {
      logic [SIZE_W-1:0] lsize;
      logic              prepared;
      lane_table_type    lanes;     // lanes[k] = LARGE_BASE + k * lsize
   } cfg_type;

   typedef struct packed {
      op_type                  op;
      logic [SMALL_BLOCKS-1:0] small_mask;
      logic [LARGE_BLOCKS-1:0] large_mask;
   } job_type;

   function automatic logic [ADDR_W-1:0] small_base(input int unsigned j);
      return ADDR_W'(j * SMALL_BLOCK_BYTES);
   endfunction

endpackage

[rtl/core/tpa_intf.sv]
// Channel interfaces: request, response and register write.
interface tpa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [tpa_pkg::SIZE_W-1:0]  size;
   logic [tpa_pkg::ADDR_W-1:0]  address;

   modport source (output valid, func, size, address, input ready);
   modport sink   (input valid, func, size, address, output ready);
endinterface

interface tpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tpa_pkg::STATUS_W-1:0]  status;
   logic [tpa_pkg::ADDR_W-1:0]    block_address;

   modport source (output valid, status, block_address, input ready);
   modport sink   (input valid, status, block_address, output ready);
endinterface

interface tpa_csr_if;
   logic                        valid;
   logic                        ready;
   logic [tpa_pkg::SIZE_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[rtl/core/tpa_front.sv]
// Front end: takes requests and classifies them into jobs for the back end.
module tpa_front (
   tpa_req_if.sink            req_bus,
   input  tpa_pkg::cfg_type   cfg,
   input  logic               q_full,
   output logic               q_push,
   output tpa_pkg::job_type   q_job
);
   import tpa_pkg::*;

   logic [LANE_W-1:0]       addr_ext;
   logic                    in_large;
   logic                    in_small;
   logic [LARGE_BLOCKS-1:0] lmask;
   logic [SMALL_BLOCKS-1:0] smask;

   assign req_bus.ready = !q_full;
   assign q_push        = req_bus.valid && !q_full;
   assign addr_ext      = {1'b0, req_bus.address};

   // one range compare per block, large pool first
   always_comb begin
      for (int k = 0; k < LARGE_BLOCKS; k++) begin
         lmask[k] = (addr_ext >= cfg.lanes[k]) && (addr_ext < cfg.lanes[k+1]);
      end
      for (int j = 0; j < SMALL_BLOCKS; j++) begin
         smask[j] = (req_bus.address >= small_base(j)) &&
                    (req_bus.address < small_base(j + 1));
      end
      in_large = (addr_ext >= cfg.lanes[0]) && (addr_ext < cfg.lanes[LARGE_BLOCKS]);
      in_small = req_bus.address < small_base(SMALL_BLOCKS);
   end

   always_comb begin
      q_job.op         = OP_PASS;
      q_job.small_mask = '0;
      q_job.large_mask = '0;
      if (!req_bus.func) begin
         if (req_bus.size == '0) begin
            q_job.op = OP_NULL;
         end else if (!cfg.prepared) begin
            q_job.op = OP_UNPREP;
         end else if (req_bus.size > cfg.lsize) begin
            q_job.op = OP_OVERSIZE;
         end else if (req_bus.size <= SIZE_W'(SMALL_BLOCK_BYTES)) begin
            q_job.op = OP_ALLOC_SMALL;
         end else begin
            q_job.op = OP_ALLOC_LARGE;
         end
      end else if (req_bus.address != '0 && cfg.prepared) begin
         if (in_large) begin
            q_job.op         = OP_FREE;
            q_job.large_mask = lmask;
         end else if (in_small) begin
            q_job.op         = OP_FREE;
            q_job.small_mask = smask;
         end
      end
   end

endmodule

[rtl/core/tpa_queue.sv]
// Short job queue between front and back end.
module tpa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tpa_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              avail,
   output tpa_pkg::job_type  pop_job
);
   import tpa_pkg::*;

   job_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full    = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign avail   = count_ff != '0;
   assign pop_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/core/tpa_back.sv]
// Back end: owns the free maps, grants and releases blocks, holds the response.
module tpa_back (
   input  logic               clock,
   input  logic               reset,
   input  tpa_pkg::cfg_type   cfg,
   input  logic               refill,
   input  logic               q_avail,
   input  tpa_pkg::job_type   q_job,
   output logic               q_pop,
   tpa_rsp_if.source          rsp_bus
);
   import tpa_pkg::*;

   logic [SMALL_BLOCKS-1:0] small_map_ff, small_map_in;
   logic [LARGE_BLOCKS-1:0] large_map_ff, large_map_in;
   logic                    out_valid_ff, out_valid_in;
   status_type              out_status_ff, out_status_in;
   logic [ADDR_W-1:0]       out_addr_ff, out_addr_in;

   logic [SMALL_BLOCKS-1:0] small_pick;
   logic [LARGE_BLOCKS-1:0] large_pick;
   logic [ADDR_W-1:0]       small_addr;
   logic [ADDR_W-1:0]       large_addr;

   assign q_pop = q_avail && (!out_valid_ff || rsp_bus.ready);

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.status        = out_status_ff;
   assign rsp_bus.block_address = out_addr_ff;

   // lowest free block: isolate the lowest set bit
   always_comb begin
      small_pick = small_map_ff & (~small_map_ff + 1'b1);
      large_pick = large_map_ff & (~large_map_ff + 1'b1);
      small_addr = '0;
      large_addr = '0;
      for (int j = 0; j < SMALL_BLOCKS; j++) begin
         small_addr = small_addr | (small_pick[j] ? small_base(j) : '0);
      end
      for (int k = 0; k < LARGE_BLOCKS; k++) begin
         large_addr = large_addr | (large_pick[k] ? cfg.lanes[k][ADDR_W-1:0] : '0);
      end
   end

   always_comb begin
      small_map_in  = small_map_ff;
      large_map_in  = large_map_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_status_in = out_status_ff;
      out_addr_in   = out_addr_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
         out_addr_in  = '0;
         unique case (q_job.op)
            OP_NULL:     out_status_in = ST_NULL;
            OP_UNPREP:   out_status_in = ST_FALLBACK;
            OP_OVERSIZE: out_status_in = ST_OVERSIZE;
            OP_ALLOC_SMALL: begin
               if (small_map_ff == '0) begin
                  out_status_in = ST_FALLBACK;
               end else begin
                  out_status_in = ST_SMALL;
                  out_addr_in   = small_addr;
                  small_map_in  = small_map_ff & ~small_pick;
               end
            end
            OP_ALLOC_LARGE: begin
               if (large_map_ff == '0) begin
                  out_status_in = ST_FALLBACK;
               end else begin
                  out_status_in = ST_LARGE;
                  out_addr_in   = large_addr;
                  large_map_in  = large_map_ff & ~large_pick;
               end
            end
            OP_FREE: begin
               out_status_in = ST_FREED;
               small_map_in  = small_map_ff | q_job.small_mask;
               large_map_in  = large_map_ff | q_job.large_mask;
            end
            default:     out_status_in = ST_PASSED;
         endcase
      end
      if (refill) begin
         small_map_in = '1;
         large_map_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_map_ff <= '1;
         large_map_ff <= '1;
         out_valid_ff <= 1'b0;
      end else begin
         small_map_ff <= small_map_in;
         large_map_ff <= large_map_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_addr_ff   <= out_addr_in;
   end

endmodule

[rtl/core/two_pool_fixed_block_allocator.sv]
// Top level of the two-pool fixed-block allocator: register, front, queue, back.
//
//   port      dir   handshake      carries
//   req_bus   in    valid/ready    func, size, address
//   rsp_bus   out   valid/ready    status, block_address
//   csr_bus   in    valid/ready    data (large_block_size)
//
// One request per cycle sustained while responses are taken; a response passes through
// the job queue and then the response register before it can be taken.
// Reset leaves the pools unprepared with every block free; csr_bus is always ready.
// A stalled response holds the back end; the front keeps taking requests until
// the queue is full.
module two_pool_fixed_block_allocator (
   input  logic        clock,
   input  logic        reset,
   tpa_req_if.sink     req_bus,
   tpa_rsp_if.source   rsp_bus,
   tpa_csr_if.sink     csr_bus
);
   import tpa_pkg::*;

   logic [SIZE_W-1:0] lsize_ff, lsize_in;
   lane_table_type    lanes_ff, lanes_in;
   logic              csr_write;
   logic              refill;
   cfg_type           cfg;

   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_avail;
   job_type           push_job;
   job_type           pop_job;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid;
   assign refill        = csr_write && (csr_bus.data != '0);

   assign cfg.lsize    = lsize_ff;
   assign cfg.prepared = lsize_ff != '0;
   assign cfg.lanes    = lanes_ff;

   // block boundaries of the large pool, fixed per register write
   always_comb begin
      lsize_in = lsize_ff;
      lanes_in = lanes_ff;
      if (csr_write) begin
         lsize_in = csr_bus.data;
         for (int k = 0; k <= LARGE_BLOCKS; k++) begin
            lanes_in[k] = LANE_W'(LARGE_BASE) + LANE_W'(k) * LANE_W'(csr_bus.data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lsize_ff <= '0;
      end else begin
         lsize_ff <= lsize_in;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
   end

   tpa_front u_front (
      .req_bus (req_bus),
      .cfg     (cfg),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_job   (push_job)
   );

   tpa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .avail    (q_avail),
      .pop_job  (pop_job)
   );

   tpa_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .refill  (refill),
      .q_avail (q_avail),
      .q_job   (pop_job),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

[tb/tb_two_pool_fixed_block_allocator.sv]
// Self-checking testbench for the two-pool fixed-block allocator.
`timescale 1ns / 1ps

module tb_two_pool_fixed_block_allocator;
   import tpa_pkg::*;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;
   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 210;

   typedef struct {
      logic              func;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
   } pool_request_type;

   typedef struct {
      status_type        status;
      logic [ADDR_W-1:0] block_address;
   } pool_reply_type;

   logic clock;
   logic reset;

   tpa_req_if req_bus ();
   tpa_rsp_if rsp_bus ();
   tpa_csr_if csr_bus ();

   two_pool_fixed_block_allocator i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state
   logic [SIZE_W-1:0]       block_size = '0;
   logic [SMALL_BLOCKS-1:0] small_map  = '1;
   logic [LARGE_BLOCKS-1:0] large_map  = '1;

   pool_request_type pending_requests[$];
   pool_reply_type   expected_replies[$];

   int idle_pct = 14;
   int errors = 0;
   int requests_taken = 0;
   int replies_checked = 0;
   int small_grants = 0;
   int large_grants = 0;
   int settings_written = 0;
   int quiet_cycles = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
   endtask

   // Expected reply for one accepted request; updates the free maps.
   function automatic pool_reply_type apply_pool_request(input pool_request_type r);
      pool_reply_type   rep;
      longint unsigned  large_end;
      longint unsigned  idx;
      rep.status        = ST_PASSED;
      rep.block_address = '0;
      large_end = longint'(LARGE_BASE) + longint'(LARGE_BLOCKS) * longint'(block_size);
      if (r.func == FUNC_ALLOC) begin
         if (r.size == 0) begin
            rep.status = ST_NULL;
         end else if (block_size == 0) begin
            rep.status = ST_FALLBACK;
         end else if (r.size > block_size) begin
            rep.status = ST_OVERSIZE;
         end else if (r.size <= SMALL_BLOCK_BYTES) begin
            rep.status = ST_FALLBACK;
            for (int k = 0; k < SMALL_BLOCKS; k++) begin
               if (small_map[k]) begin
                  small_map[k]      = 1'b0;
                  rep.status        = ST_SMALL;
                  rep.block_address = ADDR_W'(longint'(k) * SMALL_BLOCK_BYTES);
                  break;
               end
            end
         end else begin
            // never spills: an exhausted pool falls back
            rep.status = ST_FALLBACK;
            for (int k = 0; k < LARGE_BLOCKS; k++) begin
               if (large_map[k]) begin
                  large_map[k]      = 1'b0;
                  rep.status        = ST_LARGE;
                  rep.block_address = ADDR_W'(longint'(LARGE_BASE)
                                              + longint'(k) * longint'(block_size));
                  break;
               end
            end
         end
      end else if (r.addr != 0 && block_size != 0) begin
         // large range has priority over the small one
         if (r.addr >= LARGE_BASE && r.addr < large_end) begin
            idx = (longint'(r.addr) - longint'(LARGE_BASE)) / longint'(block_size);
            large_map[idx] = 1'b1;
            rep.status = ST_FREED;
         end else if (r.addr < SMALL_BLOCKS * SMALL_BLOCK_BYTES) begin
            idx = r.addr / SMALL_BLOCK_BYTES;
            small_map[idx] = 1'b1;
            rep.status = ST_FREED;
         end
      end
      return rep;
   endfunction

   function automatic pool_request_type make_request(input logic [SIZE_W-1:0] cur);
      pool_request_type r;
      int               pick;
      int               k;
      longint unsigned  offs;
      r.func = 1'($urandom);
      r.size = SIZE_W'($urandom);
      r.addr = ADDR_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 48) begin
         r.func = FUNC_ALLOC;
         pick = $urandom_range(99);
         if (pick < 6)
            r.size = '0;
         else if (pick < 12)
            r.size = SIZE_W'(SMALL_BLOCK_BYTES);
         else if (pick < 50)
            r.size = SIZE_W'($urandom_range(1, SMALL_BLOCK_BYTES));
         else if (pick < 85 && cur > SMALL_BLOCK_BYTES)
            r.size = SIZE_W'($urandom_range(SMALL_BLOCK_BYTES + 1, cur));
         else if (pick < 93 && cur < SIZE_MAX)
            r.size = SIZE_W'($urandom_range(int'(cur) + 1, SIZE_MAX));
      end else if (pick < 96) begin
         r.func = FUNC_FREE;
         pick = $urandom_range(99);
         if (pick < 45) begin
            k    = $urandom_range(0, SMALL_BLOCKS - 1);
            offs = (pick < 25) ? 0 : $urandom_range(0, SMALL_BLOCK_BYTES - 1);
            r.addr = ADDR_W'(longint'(k) * SMALL_BLOCK_BYTES + offs);
         end else if (pick < 85) begin
            // k may land on the end of the large range
            k = $urandom_range(0, LARGE_BLOCKS);
            if (pick < 65 || cur == 0)
               offs = 0;
            else if (pick < 72)
               offs = cur - 1;
            else
               offs = $urandom_range(0, int'(cur) - 1);
            r.addr = ADDR_W'(longint'(LARGE_BASE) + longint'(k) * cur + offs);
         end else if (pick < 92) begin
            r.addr = '0;
         end
      end
      return r;
   endfunction

   task automatic push_req(input logic f, input logic [SIZE_W-1:0] s,
                           input logic [ADDR_W-1:0] a);
      pool_request_type r;
      r.func = f;
      r.size = s;
      r.addr = a;
      pending_requests.push_back(r);
   endtask

   task automatic drain();
      while (pending_requests.size() != 0 || req_bus.valid || expected_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_block_size(input logic [SIZE_W-1:0] v);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      block_size = v;
      if (v != 0) begin
         small_map = '1;
         large_map = '1;
      end
      settings_written++;
   endtask

   // request driver
   always @(posedge clock) begin : driver
      pool_request_type nxt;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.func    <= 1'b0;
         req_bus.size    <= '0;
         req_bus.address <= '0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_requests.size() != 0
             && (idle_pct == 0 || $urandom_range(99) >= idle_pct)) begin
            nxt = pending_requests.pop_front();
            req_bus.valid   <= 1'b1;
            req_bus.func    <= nxt.func;
            req_bus.size    <= nxt.size;
            req_bus.address <= nxt.addr;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: predicts on request accept, checks on reply accept, watchdog
   always @(posedge clock) begin : monitor
      pool_request_type acc;
      pool_reply_type   want;
      logic             req_take;
      logic             rsp_take;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         quiet_cycles  = 0;
      end else begin
         rsp_bus.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
         req_take = req_bus.valid && req_bus.ready;
         rsp_take = rsp_bus.valid && rsp_bus.ready;
         if (req_take) begin
            acc.func = req_bus.func;
            acc.size = req_bus.size;
            acc.addr = req_bus.address;
            expected_replies.push_back(apply_pool_request(acc));
            requests_taken++;
         end
         if (rsp_take) begin
            if (expected_replies.size() == 0) begin
               report($sformatf("unexpected reply: status %0d address %h",
                                rsp_bus.status, rsp_bus.block_address));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_bus.status !== want.status
                   || rsp_bus.block_address !== want.block_address)
                  report($sformatf("reply status %0d address %h, expected %0d address %h",
                                   rsp_bus.status, rsp_bus.block_address,
                                   want.status, want.block_address));
               if (want.status == ST_SMALL)
                  small_grants++;
               if (want.status == ST_LARGE)
                  large_grants++;
               replies_checked++;
            end
         end
         if (req_take || rsp_take)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            report("nothing accepted on either side for too long");
            $display("Stopped early after %0d replies to %0d requests",
                     replies_checked, requests_taken);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      logic [SIZE_W-1:0] settings[8];
      logic [SIZE_W-1:0] cur;

      reset           <= 1'b1;
      csr_bus.valid   <= 1'b0;
      csr_bus.data    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // pools unprepared after reset
      push_req(FUNC_ALLOC, '0, '0);
      push_req(FUNC_ALLOC, SIZE_W'(5), '1);
      push_req(FUNC_FREE, SIZE_MAX, '0);
      push_req(FUNC_FREE, '0, ADDR_W'(SMALL_BLOCK_BYTES));
      push_req(FUNC_FREE, '0, ADDR_W'(LARGE_BASE));
      drain();

      write_block_size(SIZE_MAX);
      push_req(FUNC_ALLOC, SIZE_MAX, '0);
      push_req(FUNC_ALLOC, SIZE_W'(SMALL_BLOCK_BYTES + 1), '0);
      push_req(FUNC_ALLOC, SIZE_W'(SMALL_BLOCK_BYTES), '0);
      push_req(FUNC_ALLOC, SIZE_W'(1), '0);
      // block zero sits at the null address and cannot be released
      push_req(FUNC_FREE, '0, '0);
      push_req(FUNC_FREE, '0, ADDR_W'(SMALL_BLOCK_BYTES + 7));
      push_req(FUNC_FREE, '0, ADDR_W'(SMALL_BLOCK_BYTES + 7));
      push_req(FUNC_FREE, '0, ADDR_W'(LARGE_BASE + int'(SIZE_MAX) + 100));
      push_req(FUNC_FREE, '0, '1);
      push_req(FUNC_FREE, '0, ADDR_W'(SMALL_BLOCKS * SMALL_BLOCK_BYTES - 1));
      push_req(FUNC_FREE, '0, ADDR_W'(SMALL_BLOCKS * SMALL_BLOCK_BYTES));
      push_req(FUNC_ALLOC, '0, '0);
      drain();

      // oversize, then large pool exhaustion
      write_block_size(SIZE_W'(2000));
      push_req(FUNC_ALLOC, SIZE_W'(2001), '0);
      repeat (LARGE_BLOCKS + 1) push_req(FUNC_ALLOC, SIZE_W'(2000), '0);
      drain();

      settings = '{SIZE_MAX, SIZE_W'(1), SIZE_W'(SMALL_BLOCK_BYTES),
                   SIZE_W'(SMALL_BLOCK_BYTES + 1), '0,
                   SIZE_W'($urandom_range(SMALL_BLOCK_BYTES + 2, 8192)),
                   SIZE_W'($urandom_range(1, SIZE_MAX)), SIZE_MAX};
      for (int p = 0; p < 8; p++) begin
         cur = settings[p];
         write_block_size(cur);
         idle_pct = (p == 2) ? 0 : 14;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pending_requests.push_back(make_request(cur));
            // sender holds off until all replies are back
            if (p == 5 && i == PHASE_ITEMS / 2)
               drain();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Checked %0d replies to %0d requests over %0d block-size settings",
               replies_checked, requests_taken, settings_written);
      $display("Granted %0d small and %0d large blocks", small_grants, large_grants);
      if (errors == 0 && expected_replies.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/tpa_pkg.sv
rtl/core/tpa_intf.sv
rtl/core/tpa_front.sv
rtl/core/tpa_queue.sv
rtl/core/tpa_back.sv
rtl/core/two_pool_fixed_block_allocator.sv
tb/tb_two_pool_fixed_block_allocator.sv
